### rtl/bctc_pkg.sv
// Shared types, codes and constants of the block cache tag controller.
package bctc_pkg;

    localparam int BCTC_NUM_SLOTS  = 16;
    localparam int BCTC_BLOCK_BITS = 32;

    localparam int FUNC_W = 2;
    localparam int BLK_W  = 32;
    localparam int SLOT_W = 4;
    localparam int MASK_W = 16;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOOKUP = 2'd0,
        FN_MARK   = 2'd1,
        FN_FLUSH  = 2'd2
    } func_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_WB   = 2'd0,
        KIND_RD   = 2'd1,
        KIND_DONE = 2'd2
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_INVAL = 2'd1,
        ST_IO    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_DECODE,
        CS_EVICT,
        CS_FETCH,
        CS_FLUSH,
        CS_DONE
    } ctl_state_t;

    // Which completion the datapath builds.
    typedef enum logic [2:0] {
        DN_HIT,
        DN_FILL,
        DN_IO,
        DN_MARK_OK,
        DN_MARK_BAD,
        DN_FLUSH,
        DN_BAD
    } done_sel_t;

    typedef struct packed {
        logic      take;
        logic      eval;
        logic      emit;
        kind_t     emit_kind;
        logic      wb_evict;
        done_sel_t done_sel;
        logic      clean_slot0;
        logic      fill;
        logic      drop_victim;
        logic      set_dirty;
        logic      flush_wb;
        logic      ptr_inc;
    } ctl_cmd_t;

    typedef struct packed {
        logic  req_valid;
        func_t func;
        logic  hit;
        logic  has_victim;
        logic  mark_ok;
        logic  wb_fail;
        logic  fetch_fail;
        logic  ptr_dirty;
        logic  ptr_last;
        logic  space;
    } dp_stat_t;

endpackage

### rtl/bctc_if.sv
// Request and response channel interfaces of the block cache tag controller.
interface bctc_req_if
    import bctc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [BLK_W-1:0]  block_number;
    logic [SLOT_W-1:0] slot_index;
    logic              writeback_fails;
    logic              fetch_fails;
    logic [MASK_W-1:0] flush_fail_mask;

    modport source (
        output valid, func, block_number, slot_index, writeback_fails, fetch_fails,
               flush_fail_mask,
        input  ready
    );

    modport sink (
        input  valid, func, block_number, slot_index, writeback_fails, fetch_fails,
               flush_fail_mask,
        output ready
    );
endinterface

interface bctc_rsp_if
    import bctc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BLK_W-1:0]  out_block;
    logic [SLOT_W-1:0] out_slot;
    logic [STAT_W-1:0] status;
    logic              hit;
    logic              last;

    modport source (
        output valid, kind, out_block, out_slot, status, hit, last,
        input  ready
    );

    modport sink (
        input  valid, kind, out_block, out_slot, status, hit, last,
        output ready
    );
endinterface

### rtl/bctc_ctl.sv
// Controller state machine: sequences lookups, mark-dirty, flush scans and results.
module bctc_ctl
    import bctc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    ctl_state_t state_reg, state_next;
    done_sel_t  done_sel_reg, done_sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= CS_IDLE;
            done_sel_reg <= DN_BAD;
        end
        else
        begin
            state_reg    <= state_next;
            done_sel_reg <= done_sel_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        done_sel_next = done_sel_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (stat.req_valid)
                    state_next = CS_DECODE;
            end
            CS_DECODE:
            begin
                case (stat.func)
                    FN_LOOKUP:
                    begin
                        if (stat.hit)
                        begin
                            state_next    = CS_DONE;
                            done_sel_next = DN_HIT;
                        end
                        else if (stat.has_victim)
                            state_next = CS_FETCH;
                        else
                            state_next = CS_EVICT;
                    end
                    FN_MARK:
                    begin
                        state_next    = CS_DONE;
                        done_sel_next = stat.mark_ok ? DN_MARK_OK : DN_MARK_BAD;
                    end
                    FN_FLUSH:
                        state_next = CS_FLUSH;
                    default:
                    begin
                        state_next    = CS_DONE;
                        done_sel_next = DN_BAD;
                    end
                endcase
            end
            CS_EVICT:
            begin
                if (stat.space)
                begin
                    if (stat.wb_fail)
                    begin
                        state_next    = CS_DONE;
                        done_sel_next = DN_IO;
                    end
                    else
                        state_next = CS_FETCH;
                end
            end
            CS_FETCH:
            begin
                if (stat.space)
                begin
                    state_next    = CS_DONE;
                    done_sel_next = stat.fetch_fail ? DN_IO : DN_FILL;
                end
            end
            CS_FLUSH:
            begin
                if ((!stat.ptr_dirty || stat.space) && stat.ptr_last)
                begin
                    state_next    = CS_DONE;
                    done_sel_next = DN_FLUSH;
                end
            end
            CS_DONE:
            begin
                if (stat.space)
                    state_next = CS_IDLE;
            end
            default:
                state_next = CS_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.emit_kind = KIND_DONE;
        cmd.done_sel  = done_sel_reg;
        case (state_reg)
            CS_IDLE:
                cmd.take = 1'b1;
            CS_DECODE:
                cmd.eval = 1'b1;
            CS_EVICT:
            begin
                cmd.emit        = stat.space;
                cmd.emit_kind   = KIND_WB;
                cmd.wb_evict    = 1'b1;
                cmd.clean_slot0 = stat.space && !stat.wb_fail;
            end
            CS_FETCH:
            begin
                cmd.emit        = stat.space;
                cmd.emit_kind   = KIND_RD;
                cmd.fill        = stat.space && !stat.fetch_fail;
                cmd.drop_victim = stat.space && stat.fetch_fail;
            end
            CS_FLUSH:
            begin
                cmd.emit      = stat.space && stat.ptr_dirty;
                cmd.emit_kind = KIND_WB;
                cmd.flush_wb  = stat.space && stat.ptr_dirty;
                cmd.ptr_inc   = !stat.ptr_dirty || stat.space;
            end
            CS_DONE:
            begin
                cmd.emit      = stat.space;
                cmd.set_dirty = stat.space && (done_sel_reg == DN_MARK_OK);
            end
            default:
                cmd.take = 1'b0;
        endcase
    end

endmodule

### rtl/bctc_dp.sv
// Datapath: slot tags and flags, tag match, victim choice, flush pointer, result register.
module bctc_dp
    import bctc_pkg::*;
#(
    parameter int NUM_SLOTS  = BCTC_NUM_SLOTS,
    parameter int BLOCK_BITS = BCTC_BLOCK_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    bctc_req_if.sink    req,
    bctc_rsp_if.source  rsp,
    input  ctl_cmd_t    cmd,
    output dp_stat_t    stat
);

    localparam int TAG_W = (BLOCK_BITS < BLK_W) ? BLOCK_BITS : BLK_W;
    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [NUM_SLOTS-1:0] valid_reg;
    logic [NUM_SLOTS-1:0] dirty_reg;
    logic [TAG_W-1:0]     tag_reg [NUM_SLOTS];

    // Request held for the whole transaction.
    func_t             func_reg;
    logic [TAG_W-1:0]  blk_reg;
    logic [SLOT_W-1:0] slot_index_reg;
    logic              wb_fail_reg;
    logic              fetch_fail_reg;
    logic [MASK_W-1:0] mask_reg;

    logic [IDX_W-1:0]  slot_reg;
    logic [IDX_W-1:0]  ptr_reg;
    logic              flush_io_reg;

    logic              out_valid_reg;
    kind_t             kind_reg, kind_next;
    logic [BLK_W-1:0]  out_block_reg, out_block_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    status_t           status_reg, status_next;
    logic              hit_reg, hit_next;

    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic              has_inv;
    logic [IDX_W-1:0]  inv_idx;
    logic              has_clean;
    logic [IDX_W-1:0]  clean_idx;
    logic [IDX_W-1:0]  victim;
    logic [IDX_W-1:0]  wb_idx;
    logic [IDX_W-1:0]  mark_idx;
    logic              load;
    logic              space;

    assign load     = cmd.take && req.valid;
    assign space    = !out_valid_reg || rsp.ready;
    assign mark_idx = slot_index_reg[IDX_W-1:0];
    assign wb_idx   = cmd.wb_evict ? '0 : ptr_reg;

    // Lowest index wins in each search, so the loops run from the top down.
    always_comb
    begin
        hit       = 1'b0;
        hit_idx   = '0;
        has_inv   = 1'b0;
        inv_idx   = '0;
        has_clean = 1'b0;
        clean_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (tag_reg[i] == blk_reg))
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                has_inv = 1'b1;
                inv_idx = IDX_W'(i);
            end
            if (!dirty_reg[i])
            begin
                has_clean = 1'b1;
                clean_idx = IDX_W'(i);
            end
        end
    end

    assign victim = has_inv ? inv_idx : (has_clean ? clean_idx : '0);

    always_comb
    begin
        stat            = '0;
        stat.req_valid  = req.valid;
        stat.func       = func_reg;
        stat.hit        = hit;
        stat.has_victim = has_inv || has_clean;
        stat.mark_ok    = ({1'b0, slot_index_reg} < (SLOT_W + 1)'(NUM_SLOTS))
                          && valid_reg[mark_idx];
        stat.wb_fail    = wb_fail_reg;
        stat.fetch_fail = fetch_fail_reg;
        stat.ptr_dirty  = valid_reg[ptr_reg] && dirty_reg[ptr_reg];
        stat.ptr_last   = (ptr_reg == IDX_W'(NUM_SLOTS - 1));
        stat.space      = space;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            func_reg       <= func_t'(req.func);
            blk_reg        <= TAG_W'(req.block_number);
            slot_index_reg <= req.slot_index;
            wb_fail_reg    <= req.writeback_fails;
            fetch_fail_reg <= req.fetch_fails;
            mask_reg       <= req.flush_fail_mask;
        end
        if (cmd.eval)
            slot_reg <= hit ? hit_idx : victim;
        if (cmd.fill)
            tag_reg[slot_reg] <= blk_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            dirty_reg    <= '0;
            ptr_reg      <= '0;
            flush_io_reg <= 1'b0;
        end
        else
        begin
            if (cmd.eval)
            begin
                ptr_reg      <= '0;
                flush_io_reg <= 1'b0;
            end
            else if (cmd.ptr_inc)
                ptr_reg <= ptr_reg + 1'b1;
            if (cmd.clean_slot0)
                dirty_reg[0] <= 1'b0;
            if (cmd.fill)
            begin
                valid_reg[slot_reg] <= 1'b1;
                dirty_reg[slot_reg] <= 1'b0;
            end
            if (cmd.drop_victim)
                valid_reg[slot_reg] <= 1'b0;
            if (cmd.set_dirty)
                dirty_reg[mark_idx] <= 1'b1;
            if (cmd.flush_wb)
            begin
                if (mask_reg[ptr_reg])
                    flush_io_reg <= 1'b1;
                else
                    dirty_reg[ptr_reg] <= 1'b0;
            end
        end
    end

    always_comb
    begin
        kind_next      = cmd.emit_kind;
        out_block_next = '0;
        out_slot_next  = '0;
        status_next    = ST_OK;
        hit_next       = 1'b0;
        case (cmd.emit_kind)
            KIND_WB:
            begin
                out_block_next = BLK_W'(tag_reg[wb_idx]);
                out_slot_next  = SLOT_W'(wb_idx);
            end
            KIND_RD:
            begin
                out_block_next = BLK_W'(blk_reg);
                out_slot_next  = SLOT_W'(slot_reg);
            end
            default:
            begin
                case (cmd.done_sel)
                    DN_HIT:
                    begin
                        out_block_next = BLK_W'(blk_reg);
                        out_slot_next  = SLOT_W'(slot_reg);
                        hit_next       = 1'b1;
                    end
                    DN_FILL:
                    begin
                        out_block_next = BLK_W'(blk_reg);
                        out_slot_next  = SLOT_W'(slot_reg);
                    end
                    DN_IO:
                    begin
                        out_block_next = BLK_W'(blk_reg);
                        status_next    = ST_IO;
                    end
                    DN_MARK_OK:
                        out_slot_next = slot_index_reg;
                    DN_MARK_BAD:
                    begin
                        out_slot_next = slot_index_reg;
                        status_next   = ST_INVAL;
                    end
                    DN_FLUSH:
                        status_next = flush_io_reg ? ST_IO : ST_OK;
                    default:
                        status_next = ST_INVAL;
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg      <= kind_next;
            out_block_reg <= out_block_next;
            out_slot_reg  <= out_slot_next;
            status_reg    <= status_next;
            hit_reg       <= hit_next;
        end
    end

    assign req.ready     = cmd.take;
    assign rsp.valid     = out_valid_reg;
    assign rsp.kind      = kind_reg;
    assign rsp.out_block = out_block_reg;
    assign rsp.out_slot  = out_slot_reg;
    assign rsp.status    = status_reg;
    assign rsp.hit       = hit_reg;
    assign rsp.last      = (kind_reg == KIND_DONE);

endmodule

### rtl/block_cache_tag_controller.sv
// Top level of the block cache tag controller: controller plus datapath.
//
//   channel  direction  handshake     contents
//   req      in         valid/ready   func, block_number, slot_index, disk outcomes
//   rsp      out        valid/ready   kind, out_block, out_slot, status, hit, last
//
// One request transaction at a time. A lookup hit and mark-dirty pass through IDLE, DECODE
// and DONE; a lookup miss adds FETCH, and a miss that evicts slot 0 adds EVICT before FETCH.
// A flush scan visits one slot per cycle unless a dirty slot waits on a full output register.
// Each result leaves through one output register, so a stalled rsp channel holds the
// controller in place. Reset clears every slot's valid and dirty flags at once; no clearing pass.
module block_cache_tag_controller
    import bctc_pkg::*;
#(
    parameter int NUM_SLOTS  = BCTC_NUM_SLOTS,
    parameter int BLOCK_BITS = BCTC_BLOCK_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    bctc_req_if.sink    req,
    bctc_rsp_if.source  rsp
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    bctc_ctl u_ctl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    bctc_dp #(
        .NUM_SLOTS  (NUM_SLOTS),
        .BLOCK_BITS (BLOCK_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

`ifndef SYNTHESIS
    a_emit_space: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.space)
        else $error("result loaded while the output register is still full");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while a transaction is in progress");

    a_last_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.last == (rsp.kind == KIND_DONE)))
        else $error("last flag does not match a completion");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.hit) |-> (rsp.last && (rsp.status == ST_OK)))
        else $error("hit reported on something other than a good completion");
`endif

endmodule

### verif/block_cache_tag_controller_checker.sv
// Checker for the block cache tag controller: tracks slot state and compares every result.
module block_cache_tag_controller_checker
    import bctc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    bctc_req_if  req,
    bctc_rsp_if  rsp,
    output int   fail_count,
    output int   pending,
    output int   requests_seen,
    output int   results_seen,
    output int   hit_count,
    output int   evict_count,
    output int   io_count
);

    typedef struct {
        kind_t             kind;
        logic [BLK_W-1:0]  blk;
        logic [SLOT_W-1:0] slot;
        status_t           status;
        logic              hit;
        logic              last;
    } cache_result_t;

    cache_result_t     expected_results[$];
    logic              slot_valid[BCTC_NUM_SLOTS];
    logic              slot_dirty[BCTC_NUM_SLOTS];
    logic [BLK_W-1:0]  slot_tag[BCTC_NUM_SLOTS];

    int fails;
    int n_requests;
    int n_results;
    int n_hits;
    int n_evicts;
    int n_io;

    function automatic void push_result(kind_t k, logic [BLK_W-1:0] b, logic [SLOT_W-1:0] s,
                                        status_t st, logic h, logic l);
        cache_result_t r;
        r.kind   = k;
        r.blk    = b;
        r.slot   = s;
        r.status = st;
        r.hit    = h;
        r.last   = l;
        expected_results.push_back(r);
        if (k == KIND_DONE && st == ST_IO)
            n_io++;
    endfunction

    function automatic void predict_lookup(logic [BLK_W-1:0] blk, logic wb_fail,
                                           logic rd_fail);
        int victim;
        victim = -1;
        for (int i = 0; i < BCTC_NUM_SLOTS; i++)
        begin
            if (slot_valid[i] && slot_tag[i] == blk)
            begin
                push_result(KIND_DONE, blk, SLOT_W'(i), ST_OK, 1'b1, 1'b1);
                n_hits++;
                return;
            end
        end
        // Victim choice: first invalid slot, then first clean slot, else slot 0.
        for (int i = 0; i < BCTC_NUM_SLOTS; i++)
            if (victim < 0 && !slot_valid[i])
                victim = i;
        for (int i = 0; i < BCTC_NUM_SLOTS; i++)
            if (victim < 0 && !slot_dirty[i])
                victim = i;
        if (victim < 0)
        begin
            victim = 0;
            n_evicts++;
            push_result(KIND_WB, slot_tag[0], '0, ST_OK, 1'b0, 1'b0);
            if (wb_fail)
            begin
                push_result(KIND_DONE, blk, '0, ST_IO, 1'b0, 1'b1);
                return;
            end
            slot_dirty[0] = 1'b0;
        end
        push_result(KIND_RD, blk, SLOT_W'(victim), ST_OK, 1'b0, 1'b0);
        if (rd_fail)
        begin
            slot_valid[victim] = 1'b0;
            push_result(KIND_DONE, blk, '0, ST_IO, 1'b0, 1'b1);
            return;
        end
        slot_tag[victim]   = blk;
        slot_valid[victim] = 1'b1;
        slot_dirty[victim] = 1'b0;
        push_result(KIND_DONE, blk, SLOT_W'(victim), ST_OK, 1'b0, 1'b1);
    endfunction

    function automatic void predict_mark(logic [SLOT_W-1:0] s);
        if (int'(s) >= BCTC_NUM_SLOTS || !slot_valid[s])
        begin
            push_result(KIND_DONE, '0, s, ST_INVAL, 1'b0, 1'b1);
            return;
        end
        slot_dirty[s] = 1'b1;
        push_result(KIND_DONE, '0, s, ST_OK, 1'b0, 1'b1);
    endfunction

    function automatic void predict_flush(logic [MASK_W-1:0] fail_mask);
        status_t st;
        st = ST_OK;
        for (int i = 0; i < BCTC_NUM_SLOTS; i++)
        begin
            if (slot_valid[i] && slot_dirty[i])
            begin
                push_result(KIND_WB, slot_tag[i], SLOT_W'(i), ST_OK, 1'b0, 1'b0);
                // A slot whose writeback fails keeps its dirty bit.
                if (fail_mask[i])
                    st = ST_IO;
                else
                    slot_dirty[i] = 1'b0;
            end
        end
        push_result(KIND_DONE, '0, '0, st, 1'b0, 1'b1);
    endfunction

    function automatic void check_field(string name, logic [BLK_W-1:0] want,
                                        logic [BLK_W-1:0] got);
        if (got !== want)
        begin
            fails++;
            $display("%0t: mismatch in %s: expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cache_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < BCTC_NUM_SLOTS; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_dirty[i] = 1'b0;
                slot_tag[i]   = '0;
            end
            expected_results.delete();
            fails      = 0;
            n_requests = 0;
            n_results  = 0;
            n_hits     = 0;
            n_evicts   = 0;
            n_io       = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                n_requests++;
                case (req.func)
                    FN_LOOKUP: predict_lookup(req.block_number, req.writeback_fails,
                                              req.fetch_fails);
                    FN_MARK:   predict_mark(req.slot_index);
                    FN_FLUSH:  predict_flush(req.flush_fail_mask);
                    default:   push_result(KIND_DONE, '0, '0, ST_INVAL, 1'b0, 1'b1);
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                n_results++;
                if (expected_results.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result: expected none, actual kind=%0d",
                             $time, rsp.kind);
                    $display("    block=%h slot=%0d status=%0d hit=%b last=%b",
                             rsp.out_block, rsp.out_slot, rsp.status, rsp.hit, rsp.last);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("kind", BLK_W'(want.kind), BLK_W'(rsp.kind));
                    check_field("out_block", want.blk, rsp.out_block);
                    check_field("out_slot", BLK_W'(want.slot), BLK_W'(rsp.out_slot));
                    check_field("status", BLK_W'(want.status), BLK_W'(rsp.status));
                    check_field("hit", BLK_W'(want.hit), BLK_W'(rsp.hit));
                    check_field("last", BLK_W'(want.last), BLK_W'(rsp.last));
                end
            end
        end
        fail_count    <= fails;
        pending       <= expected_results.size();
        requests_seen <= n_requests;
        results_seen  <= n_results;
        hit_count     <= n_hits;
        evict_count   <= n_evicts;
        io_count      <= n_io;
    end

endmodule

### verif/block_cache_tag_controller_tb.sv
// Testbench top of the block cache tag controller: clock, reset, stimulus and verdict.
module block_cache_tag_controller_tb;
    import bctc_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 7;
    localparam int IDLE_PCT     = 23;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int ITEM_TARGET  = 450;
    localparam int POOL_SIZE    = 24;
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    bctc_req_if req_ch();
    bctc_rsp_if rsp_ch();

    int fail_count;
    int pending;
    int requests_seen;
    int results_seen;
    int hit_count;
    int evict_count;
    int io_count;

    int quiet_cycles;
    int items_sent;
    bit calm;
    bit hold_request;
    logic [BLK_W-1:0] blk_pool[POOL_SIZE];

    always #HALF_PERIOD clk = ~clk;

    block_cache_tag_controller dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    block_cache_tag_controller_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .requests_seen (requests_seen),
        .results_seen  (results_seen),
        .hit_count     (hit_count),
        .evict_count   (evict_count),
        .io_count      (io_count)
    );

    // Watchdog: cycles in which neither channel completes a transaction.
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL block_cache_tag_controller");
        $finish;
    end

    // Response side: random back-pressure, one long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (calm || !rst_n)
                rsp_ch.ready <= rst_n;
            else
                rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [BLK_W-1:0] blk,
                                input logic [SLOT_W-1:0] slot, input logic wb_fail,
                                input logic rd_fail, input logic [MASK_W-1:0] fail_mask);
        int gap;
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.func            <= fn;
        req_ch.block_number    <= blk;
        req_ch.slot_index      <= slot;
        req_ch.writeback_fails <= wb_fail;
        req_ch.fetch_fails     <= rd_fail;
        req_ch.flush_fail_mask <= fail_mask;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
    endtask

    // Fields that an operation ignores are randomized all the same.
    task automatic lookup_block(input logic [BLK_W-1:0] blk, input logic wb_fail,
                                input logic rd_fail);
        send_request(FN_LOOKUP, blk, SLOT_W'($urandom_range(15)), wb_fail, rd_fail,
                     MASK_W'($urandom));
    endtask

    task automatic mark_slot(input logic [SLOT_W-1:0] slot);
        send_request(FN_MARK, $urandom, slot, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     MASK_W'($urandom));
    endtask

    task automatic flush_all(input logic [MASK_W-1:0] fail_mask);
        send_request(FN_FLUSH, $urandom, SLOT_W'($urandom_range(15)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), fail_mask);
    endtask

    function automatic logic [MASK_W-1:0] pick_fail_mask();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return MASK_W'($urandom);
        endcase
    endfunction

    // Look up a fresh block per slot, mark all or some slots dirty, then force misses and a flush.
    task automatic fill_and_evict();
        bit all_dirty;
        int misses;
        all_dirty = ($urandom_range(99) < 60);
        for (int i = 0; i < BCTC_NUM_SLOTS; i++)
            lookup_block($urandom, 1'($urandom_range(1)), ($urandom_range(99) < 5));
        for (int i = 0; i < BCTC_NUM_SLOTS; i++)
            if (all_dirty || $urandom_range(99) < 70)
                mark_slot(SLOT_W'(i));
        misses = $urandom_range(1, 4);
        for (int i = 0; i < misses; i++)
        begin
            lookup_block($urandom, 1'($urandom_range(1)), ($urandom_range(99) < 25));
            if ($urandom_range(1))
                mark_slot(SLOT_W'($urandom_range(15)));
        end
        flush_all(pick_fail_mask());
    endtask

    task automatic mixed_burst();
        int count;
        int pick;
        count = $urandom_range(8, 20);
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                lookup_block(blk_pool[$urandom_range(POOL_SIZE - 1)],
                             1'($urandom_range(1)), ($urandom_range(99) < 15));
            else if (pick < 80)
                mark_slot(SLOT_W'($urandom_range(15)));
            else if (pick < 90)
                flush_all(pick_fail_mask());
            else
                send_request(FUNC_W'($urandom_range(3)), $urandom,
                             SLOT_W'($urandom_range(15)), 1'($urandom_range(1)),
                             1'($urandom_range(1)), MASK_W'($urandom));
        end
    endtask

    initial
    begin
        rst_n                  <= 1'b0;
        req_ch.valid           <= 1'b0;
        req_ch.func            <= FN_LOOKUP;
        req_ch.block_number    <= '0;
        req_ch.slot_index      <= '0;
        req_ch.writeback_fails <= 1'b0;
        req_ch.fetch_fails     <= 1'b0;
        req_ch.flush_fail_mask <= '0;
        calm         = 1'b0;
        hold_request = 1'b0;
        items_sent   = 0;
        blk_pool[0] = '0;
        blk_pool[1] = '1;
        blk_pool[2] = 32'h8000_0000;
        blk_pool[3] = 32'h0000_0001;
        for (int i = 4; i < POOL_SIZE; i++)
            blk_pool[i] = $urandom;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: rejects on an empty cache, fills, hits, fetch failure, flushes.
        mark_slot(SLOT_W'(0));
        mark_slot(SLOT_W'(BCTC_NUM_SLOTS - 1));
        flush_all('1);
        send_request(FN_UNUSED, '1, '1, 1'b1, 1'b1, '1);
        lookup_block('0, 1'b1, 1'b0);
        lookup_block('0, 1'b0, 1'b0);
        lookup_block('1, 1'b0, 1'b1);
        lookup_block('1, 1'b0, 1'b0);
        mark_slot(SLOT_W'(1));
        mark_slot(SLOT_W'(0));
        mark_slot(SLOT_W'(2));
        flush_all(16'h0001);
        flush_all('0);
        flush_all('0);
        lookup_block(32'h8000_0000, 1'b0, 1'b0);
        lookup_block(32'h7FFF_FFFF, 1'b1, 1'b0);
        mark_slot(SLOT_W'(1));
        lookup_block(32'h0000_0001, 1'b0, 1'b0);
        lookup_block('1, 1'b0, 1'b0);
        flush_all(16'hFFFE);

        // Random part; the response side holds off once while requests keep coming.
        hold_request = 1'b1;
        while (items_sent < ITEM_TARGET)
        begin
            calm = (items_sent >= 200 && items_sent < 300);
            case ($urandom_range(9))
                0, 1, 2: fill_and_evict();
                default: mixed_burst();
            endcase
        end
        calm = 1'b0;
        req_ch.valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests and %0d results, with %0d lookup hits,",
                 requests_seen, results_seen, hit_count);
        $display("%0d slot 0 evictions and %0d I/O error completions.", evict_count, io_count);
        if (fail_count == 0)
            $display("PASS block_cache_tag_controller");
        else
            $display("FAIL block_cache_tag_controller");
        $finish;
    end

endmodule
